// ===== hdl/idiv64_pkg.sv =====
// Package for the 64-bit integer divider.
// Holds the operation codes, data widths and iteration count shared by the RTL.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package idiv64_pkg;

	localparam int DATA_W = 64;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_UQUO = 2'd0;
	localparam logic [OP_W-1:0] OP_UREM = 2'd1;
	localparam logic [OP_W-1:0] OP_SQUO = 2'd2;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

// ===== hdl/integer_divider_64.sv =====
// Top level of the 64-bit integer divider: unsigned quotient, unsigned remainder
// and signed quotient by restoring division, one quotient bit per cycle.
// Depends on idiv64_pkg.
// A new transaction is accepted only in the idle state; in_stall is high from then
// until the result is written to the output register. The 65-bit subtractor
// resolves one quotient bit per cycle, over all 64 dividend bits.
// A finished result waits in the output register while the next transaction runs.
// Reset clears the sequencer and the output valid; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_divider_64
	import idiv64_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [OP_W-1:0]  op,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [DATA_W-1:0]     result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIX  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OP_W-1:0]  op_q;
	logic             neg_q;
	logic             zero_q;
	word_t            rem_q;
	word_t            quo_q;
	word_t            den_q;
	logic             out_valid_q;
	word_t            result_q;

	logic             out_free;
	logic [DATA_W:0]  trial;
	logic             fits;
	word_t            final_val;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, den_q};
	assign fits  = !trial[DATA_W];

	always_comb begin
		final_val = '0;
		if (!zero_q) begin
			case (op_q)
				OP_UQUO: final_val = quo_q;
				OP_UREM: final_val = rem_q;
				OP_SQUO: final_val = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
				default: final_val = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q  <= op;
					quo_q <= dividend;
					den_q <= divisor;
				end
			end
			ST_LOAD: begin
				rem_q  <= '0;
				cnt_q  <= '0;
				zero_q <= (den_q == '0);
				neg_q  <= quo_q[DATA_W-1] ^ den_q[DATA_W-1];
				if (op_q == OP_SQUO) begin
					if (quo_q[DATA_W-1]) begin
						quo_q <= DATA_W'(0) - quo_q;
					end
					if (den_q[DATA_W-1]) begin
						den_q <= DATA_W'(0) - den_q;
					end
				end
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (fits) begin
					rem_q <= trial[DATA_W-1:0];
				end else begin
					rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				end
				quo_q <= {quo_q[DATA_W-2:0], fits};
			end
			ST_FIX: begin
				if (out_free) begin
					result_q <= final_val;
				end
			end
			default: begin
			end
		endcase
	end

	// The partial remainder stays below the divisor throughout the iteration.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !zero_q) |-> (rem_q < den_q))
		else $error("partial remainder reached the divisor");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_FIX))
		else $error("division did not end after the last quotient bit");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX && zero_q && out_free) |=> (out_valid && result == '0))
		else $error("zero divisor gave a nonzero result");

	a_out_from_fix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIX))
		else $error("result presented outside the fix-up step");

endmodule

`default_nettype wire
